// ===== hdl/euler_angles_to_basis_vectors_unit_assert.svh =====
// Assertion macros for the unit file, which checks itself.
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_UNIT_ASSERT_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EABV_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eabv: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define EABV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eabv: next-cycle check failed");

`endif

// ===== hdl/eabv_pkg.sv =====
package eabv_pkg;

   typedef struct packed {
      logic signed [31:0] sin_value;
      logic signed [31:0] cos_value;
   } sincos_type;

   localparam logic [31:0] HALF_PI_Q31 = 32'hC90F_DAA2;
   localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
   localparam int unsigned SERIES_STEPS = 7;
   localparam int unsigned TRIG_LATENCY = 2 + 2 * SERIES_STEPS + 1;
   localparam int unsigned COMB_LATENCY = 3;

   localparam int unsigned SIN_SH [6] = '{35, 37, 38, 39, 39, 40};
   localparam logic [32:0] SIN_MUL [6] = '{
      33'(((65'd1 << 35) + 65'd5) / 65'd6),
      33'(((65'd1 << 37) + 65'd19) / 65'd20),
      33'(((65'd1 << 38) + 65'd41) / 65'd42),
      33'(((65'd1 << 39) + 65'd71) / 65'd72),
      33'(((65'd1 << 39) + 65'd109) / 65'd110),
      33'(((65'd1 << 40) + 65'd155) / 65'd156)
   };

   localparam int unsigned COS_SH [7] = '{33, 36, 37, 38, 39, 40, 40};
   localparam logic [32:0] COS_MUL [7] = '{
      33'(((65'd1 << 33) + 65'd1) / 65'd2),
      33'(((65'd1 << 36) + 65'd11) / 65'd12),
      33'(((65'd1 << 37) + 65'd29) / 65'd30),
      33'(((65'd1 << 38) + 65'd55) / 65'd56),
      33'(((65'd1 << 39) + 65'd89) / 65'd90),
      33'(((65'd1 << 40) + 65'd131) / 65'd132),
      33'(((65'd1 << 40) + 65'd181) / 65'd182)
   };

endpackage

// ===== hdl/eabv_trig.sv =====
module eabv_trig
   import eabv_pkg::*;
#(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [ANGLE_WIDTH-1:0] angle,
   output sincos_type             result
);

   logic [29:0]        frac;
   logic [61:0]        phase_prod;
   logic [30:0]        x_ff;
   logic [1:0]         quad1_ff;
   logic [61:0]        sq_prod;

   logic [31:0]        x2_ff   [0:6];
   logic [1:0]         quad_ff [0:7];
   logic signed [33:0] sacc_ff [0:7];
   logic signed [33:0] cacc_ff [0:7];
   logic [31:0]        st_ff   [0:6];
   logic [31:0]        ct_ff   [0:7];

   logic [31:0]        x2m_ff   [0:6];
   logic [1:0]         quadm_ff [0:6];
   logic signed [33:0] saccm_ff [0:6];
   logic signed [33:0] caccm_ff [0:6];
   logic [31:0]        vs_ff    [0:5];
   logic [31:0]        vc_ff    [0:6];

   logic [63:0]        ps_w     [0:6];
   logic [63:0]        pc_w     [0:6];
   logic signed [33:0] saccm_in [0:6];
   logic signed [33:0] caccm_in [0:6];
   logic [64:0]        qs_w     [0:5];
   logic [64:0]        qc_w     [0:6];

   logic signed [33:0] s_sum;
   logic signed [33:0] c_sum;
   logic [31:0]        s_cl;
   logic [31:0]        c_cl;
   sincos_type         result_in;
   sincos_type         result_ff;

   assign frac       = {angle[ANGLE_WIDTH-3:0], {(32-ANGLE_WIDTH){1'b0}}};
   assign phase_prod = 62'(frac) * 62'(HALF_PI_Q31);
   assign sq_prod    = 62'(x_ff) * 62'(x_ff);

   always_comb begin
      for (int g = 0; g < 7; g++) begin
         ps_w[g] = 64'(st_ff[g]) * 64'(x2_ff[g]);
         pc_w[g] = 64'(ct_ff[g]) * 64'(x2_ff[g]);
         if (g % 2 == 1) begin
            saccm_in[g] = sacc_ff[g] - signed'({2'b00, st_ff[g]});
            caccm_in[g] = cacc_ff[g] - signed'({2'b00, ct_ff[g]});
         end else begin
            saccm_in[g] = sacc_ff[g] + signed'({2'b00, st_ff[g]});
            caccm_in[g] = cacc_ff[g] + signed'({2'b00, ct_ff[g]});
         end
      end
      for (int g = 0; g < 6; g++) begin
         qs_w[g] = (65'(vs_ff[g]) * 65'(SIN_MUL[g])) >> SIN_SH[g];
      end
      for (int g = 0; g < 7; g++) begin
         qc_w[g] = (65'(vc_ff[g]) * 65'(COS_MUL[g])) >> COS_SH[g];
      end
   end

   always_comb begin
      s_sum = sacc_ff[7];
      c_sum = cacc_ff[7] - signed'({2'b00, ct_ff[7]});
      if (s_sum < 0) begin
         s_cl = '0;
      end else if (s_sum > signed'({2'b00, Q30_ONE})) begin
         s_cl = Q30_ONE;
      end else begin
         s_cl = s_sum[31:0];
      end
      if (c_sum < 0) begin
         c_cl = '0;
      end else if (c_sum > signed'({2'b00, Q30_ONE})) begin
         c_cl = Q30_ONE;
      end else begin
         c_cl = c_sum[31:0];
      end
      case (quad_ff[7])
         2'd0: begin
            result_in.sin_value = signed'(s_cl);
            result_in.cos_value = signed'(c_cl);
         end
         2'd1: begin
            result_in.sin_value = signed'(c_cl);
            result_in.cos_value = -signed'(s_cl);
         end
         2'd2: begin
            result_in.sin_value = -signed'(s_cl);
            result_in.cos_value = -signed'(c_cl);
         end
         default: begin
            result_in.sin_value = -signed'(c_cl);
            result_in.cos_value = signed'(s_cl);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff       <= phase_prod[61:31];
         quad1_ff   <= angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
         x2_ff[0]   <= sq_prod[61:30];
         quad_ff[0] <= quad1_ff;
         sacc_ff[0] <= '0;
         cacc_ff[0] <= '0;
         st_ff[0]   <= 32'(x_ff);
         ct_ff[0]   <= Q30_ONE;
         for (int g = 0; g < 7; g++) begin
            x2m_ff[g]   <= x2_ff[g];
            quadm_ff[g] <= quad_ff[g];
            saccm_ff[g] <= saccm_in[g];
            caccm_ff[g] <= caccm_in[g];
            vc_ff[g]    <= pc_w[g][61:30];
            if (g < 6) begin
               vs_ff[g]   <= ps_w[g][61:30];
               x2_ff[g+1] <= x2m_ff[g];
               st_ff[g+1] <= qs_w[g][31:0];
            end
            quad_ff[g+1] <= quadm_ff[g];
            sacc_ff[g+1] <= saccm_ff[g];
            cacc_ff[g+1] <= caccm_ff[g];
            ct_ff[g+1]   <= qc_w[g][31:0];
         end
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== hdl/eabv_comb.sv =====
module eabv_comb
   import eabv_pkg::*;
#(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              enable,
   input  sincos_type                        pitch_sc,
   input  sincos_type                        yaw_sc,
   input  sincos_type                        roll_sc,
   output logic signed [COMPONENT_WIDTH-1:0] forward_x,
   output logic signed [COMPONENT_WIDTH-1:0] forward_y,
   output logic signed [COMPONENT_WIDTH-1:0] forward_z,
   output logic signed [COMPONENT_WIDTH-1:0] right_x,
   output logic signed [COMPONENT_WIDTH-1:0] right_y,
   output logic signed [COMPONENT_WIDTH-1:0] right_z,
   output logic signed [COMPONENT_WIDTH-1:0] up_x,
   output logic signed [COMPONENT_WIDTH-1:0] up_y,
   output logic signed [COMPONENT_WIDTH-1:0] up_z
);

   localparam int SH = 31 - COMPONENT_WIDTH;
   localparam logic [33:0] MAXV = 34'((64'd1 << (COMPONENT_WIDTH - 1)) - 64'd1);
   localparam logic [33:0] HALF = 34'(64'd1 << (SH - 1));

   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic        neg;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] p;
      logic [31:0] r;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? 32'(-a) : 32'(a);
      mb  = (b < 0) ? 32'(-b) : 32'(b);
      p   = 64'(ma) * 64'(mb) + (64'd1 << 29);
      r   = p[61:30];
      return neg ? -signed'(r) : signed'(r);
   endfunction

   function automatic logic [COMPONENT_WIDTH-1:0] to_out(input logic signed [33:0] v);
      logic        neg;
      logic [33:0] mag;
      logic [33:0] r;
      neg = v < 0;
      mag = neg ? 34'(-v) : 34'(v);
      r   = (mag + HALF) >> SH;
      if (r > MAXV) begin
         r = MAXV;
      end
      return neg ? COMPONENT_WIDTH'(-r) : COMPONENT_WIDTH'(r);
   endfunction

   logic signed [31:0] t_ff, u_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff;
   logic signed [31:0] srcp_ff, srsy_ff, srcy_ff, crcp_ff, sp1_ff, cy1_ff, sy1_ff;
   logic signed [31:0] tcy_ff, tsy_ff, ucy_ff, usy_ff;
   logic signed [31:0] cpcy2_ff, cpsy2_ff, crsy2_ff, crcy2_ff;
   logic signed [31:0] srcp2_ff, srsy2_ff, srcy2_ff, crcp2_ff, sp2_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff    <= qmul(roll_sc.sin_value, pitch_sc.sin_value);
         u_ff    <= qmul(roll_sc.cos_value, pitch_sc.sin_value);
         cpcy_ff <= qmul(pitch_sc.cos_value, yaw_sc.cos_value);
         cpsy_ff <= qmul(pitch_sc.cos_value, yaw_sc.sin_value);
         crsy_ff <= qmul(roll_sc.cos_value, yaw_sc.sin_value);
         crcy_ff <= qmul(roll_sc.cos_value, yaw_sc.cos_value);
         srcp_ff <= qmul(roll_sc.sin_value, pitch_sc.cos_value);
         srsy_ff <= qmul(roll_sc.sin_value, yaw_sc.sin_value);
         srcy_ff <= qmul(roll_sc.sin_value, yaw_sc.cos_value);
         crcp_ff <= qmul(roll_sc.cos_value, pitch_sc.cos_value);
         sp1_ff  <= pitch_sc.sin_value;
         cy1_ff  <= yaw_sc.cos_value;
         sy1_ff  <= yaw_sc.sin_value;

         tcy_ff   <= qmul(t_ff, cy1_ff);
         tsy_ff   <= qmul(t_ff, sy1_ff);
         ucy_ff   <= qmul(u_ff, cy1_ff);
         usy_ff   <= qmul(u_ff, sy1_ff);
         cpcy2_ff <= cpcy_ff;
         cpsy2_ff <= cpsy_ff;
         crsy2_ff <= crsy_ff;
         crcy2_ff <= crcy_ff;
         srcp2_ff <= srcp_ff;
         srsy2_ff <= srsy_ff;
         srcy2_ff <= srcy_ff;
         crcp2_ff <= crcp_ff;
         sp2_ff   <= sp1_ff;

         forward_x <= to_out(34'(cpcy2_ff));
         forward_y <= to_out(34'(cpsy2_ff));
         forward_z <= to_out(-34'(sp2_ff));
         right_x   <= to_out(34'(crsy2_ff) - 34'(tcy_ff));
         right_y   <= to_out(-34'(tsy_ff) - 34'(crcy2_ff));
         right_z   <= to_out(-34'(srcp2_ff));
         up_x      <= to_out(34'(ucy_ff) + 34'(srsy2_ff));
         up_y      <= to_out(34'(usy_ff) - 34'(srcy2_ff));
         up_z      <= to_out(34'(crcp2_ff));
      end
   end

endmodule

// ===== hdl/euler_angles_to_basis_vectors_unit.sv =====
// Channel | Dir | Ports       | Contents
// req     | in  | req_t*      | pitch, yaw and roll binary angles
// rsp     | out | rsp_t*      | forward, right and up vectors, nine components
//
// One transfer is accepted per cycle while no stalled result holds the pipeline.
// Reset clears only the valid bits; data registers are not reset.
// A stalled result freezes the whole pipeline in place, so nothing is lost.
`include "euler_angles_to_basis_vectors_unit_assert.svh"

module euler_angles_to_basis_vectors_unit
   import eabv_pkg::*;
#(
   parameter int ANGLE_WIDTH     = 16,
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // pitch_angle, yaw_angle, roll_angle, then zero fill
   input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // forward_x, forward_y, forward_z, right_x, right_y, right_z, up_x, up_y, up_z,
   // then zero fill
   output logic [((9*COMPONENT_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   localparam int LAT   = TRIG_LATENCY + COMB_LATENCY;
   localparam int OUT_W = ((9*COMPONENT_WIDTH+7)/8)*8;
   localparam int PAD_W = OUT_W - 9*COMPONENT_WIDTH;

   logic           enable;
   logic [LAT-1:0] valid_ff;
   logic [LAT-1:0] valid_in;
   sincos_type     pitch_sc, yaw_sc, roll_sc;
   logic signed [COMPONENT_WIDTH-1:0] forward_x, forward_y, forward_z;
   logic signed [COMPONENT_WIDTH-1:0] right_x, right_y, right_z;
   logic signed [COMPONENT_WIDTH-1:0] up_x, up_y, up_z;

   assign enable     = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = valid_ff[LAT-1];
   assign valid_in   = enable ? {valid_ff[LAT-2:0], req_tvalid} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   eabv_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
      .clock  (clock),
      .enable (enable),
      .angle  (req_tdata[ANGLE_WIDTH-1:0]),
      .result (pitch_sc)
   );

   eabv_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
      .clock  (clock),
      .enable (enable),
      .angle  (req_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
      .result (yaw_sc)
   );

   eabv_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
      .clock  (clock),
      .enable (enable),
      .angle  (req_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]),
      .result (roll_sc)
   );

   eabv_comb #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_comb (
      .clock     (clock),
      .enable    (enable),
      .pitch_sc  (pitch_sc),
      .yaw_sc    (yaw_sc),
      .roll_sc   (roll_sc),
      .forward_x (forward_x),
      .forward_y (forward_y),
      .forward_z (forward_z),
      .right_x   (right_x),
      .right_y   (right_y),
      .right_z   (right_z),
      .up_x      (up_x),
      .up_y      (up_y),
      .up_z      (up_z)
   );

   generate
      if (PAD_W > 0) begin : g_pad
         assign rsp_tdata = {PAD_W'(0), up_z, up_y, up_x, right_z, right_y, right_x,
                             forward_z, forward_y, forward_x};
      end else begin : g_nopad
         assign rsp_tdata = {up_z, up_y, up_x, right_z, right_y, right_x,
                             forward_z, forward_y, forward_x};
      end
   endgenerate

   `EABV_ASSERT_SAME(a_stall_blocks_input, clock, reset,
                     rsp_tvalid && !rsp_tready, !req_tready)
   `EABV_ASSERT_SAME(a_empty_output_accepts, clock, reset,
                     !rsp_tvalid, req_tready)
   `EABV_ASSERT_NEXT(a_accept_enters_pipe, clock, reset,
                     req_tvalid && req_tready, valid_ff[0])

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import eabv_pkg::*;

   localparam int AW = 16;
   localparam int CW = 16;
   localparam int IN_BITS = ((3*AW+7)/8)*8;
   localparam int OUT_BITS = ((9*CW+7)/8)*8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 450;
   localparam int N_DIRECTED = 16;
   localparam logic [15:0] POS_SAT = 16'sd32767;
   localparam logic [15:0] NEG_SAT = -16'sd32767;

   typedef logic [15:0] vec9_t [9];

   typedef struct {
      logic [15:0] pitch;
      logic [15:0] yaw;
      logic [15:0] roll;
      bit          known;
      logic [15:0] fx;
      logic [15:0] fy;
      logic [15:0] fz;
      logic [15:0] uz;
   } angle_row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [IN_BITS-1:0]  req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [OUT_BITS-1:0] rsp_tdata;

   logic [OUT_BITS-1:0] expected_vectors [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  send_gap_pct = 0;
   int  stall_pct = 0;
   bit  hold_off = 1'b0;
   bit  stimulus_done = 1'b0;
   angle_row_t directed_rows [N_DIRECTED];

   euler_angles_to_basis_vectors_unit #(
      .ANGLE_WIDTH(AW),
      .COMPONENT_WIDTH(CW)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void sine_cosine(input logic [15:0] angle, output longint sn,
                                       output longint cs);
      longint unsigned p, f, x, x2, term;
      longint s, c;
      int quad;
      p = {32'd0, angle, 16'd0};
      quad = int'(p >> 30) & 3;
      f = p & 64'h3FFF_FFFF;
      x = (f * 64'hC90F_DAA2) >> 31;
      x2 = (x * x) >> 30;
      s = longint'(x);
      term = x;
      for (int k = 1; k <= 6; k++) begin
         term = ((term * x2) >> 30) / longint'((2*k) * (2*k+1));
         if (k & 1) s -= longint'(term); else s += longint'(term);
      end
      c = 64'sd1 <<< 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / longint'((2*k-1) * (2*k));
         if (k & 1) c -= longint'(term); else c += longint'(term);
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      if (c < 0) c = 0;
      if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
      case (quad)
         0: begin sn = s;  cs = c;  end
         1: begin sn = c;  cs = -s; end
         2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   function automatic longint q30_product(longint a, longint b);
      bit neg;
      longint unsigned ma, mb, r;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? longint'(-a) : a;
      mb = (b < 0) ? longint'(-b) : b;
      r = (ma * mb + (64'd1 << 29)) >> 30;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [15:0] to_component(longint v);
      bit neg;
      longint unsigned mag, r;
      neg = v < 0;
      mag = neg ? longint'(-v) : v;
      r = (mag + (64'd1 << (30 - CW))) >> (31 - CW);
      if (r > 32767) r = 32767;
      return neg ? 16'(-r) : 16'(r);
   endfunction

   function automatic logic [OUT_BITS-1:0] basis_vectors(logic [15:0] pitch, logic [15:0] yaw,
                                                         logic [15:0] roll);
      longint sp, cp, sy, cy, sr, cr, t, u;
      vec9_t c;
      logic [OUT_BITS-1:0] packed_out;
      sine_cosine(pitch, sp, cp);
      sine_cosine(yaw, sy, cy);
      sine_cosine(roll, sr, cr);
      t = q30_product(sr, sp);
      u = q30_product(cr, sp);
      c[0] = to_component(q30_product(cp, cy));
      c[1] = to_component(q30_product(cp, sy));
      c[2] = to_component(-sp);
      c[3] = to_component(-q30_product(t, cy) + q30_product(cr, sy));
      c[4] = to_component(-q30_product(t, sy) - q30_product(cr, cy));
      c[5] = to_component(-q30_product(sr, cp));
      c[6] = to_component(q30_product(u, cy) + q30_product(sr, sy));
      c[7] = to_component(q30_product(u, sy) - q30_product(sr, cy));
      c[8] = to_component(q30_product(cr, cp));
      packed_out = '0;
      for (int i = 0; i < 9; i++) packed_out[i*CW +: CW] = c[i];
      return packed_out;
   endfunction

   task automatic report_mismatch(input string what, input int idx, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      $display("Mismatch on %s component %0d: got %h, expected %h", what, idx, got, want);
   endtask

   task automatic send_angles(input logic [15:0] pitch, input logic [15:0] yaw,
                              input logic [15:0] roll);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pitch, yaw, roll} == 48'h0 ? '0 : {roll, yaw, pitch};
      expected_vectors.push_back(basis_vectors(pitch, yaw, roll));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_vectors.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      logic [OUT_BITS-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_vectors.size() == 0) begin
            report_mismatch("unexpected transfer", 0, rsp_tdata[15:0], 16'h0);
         end else begin
            want = expected_vectors.pop_front();
            for (int i = 0; i < 9; i++)
               if (rsp_tdata[i*CW +: CW] !== want[i*CW +: CW])
                  report_mismatch("result", i, rsp_tdata[i*CW +: CW], want[i*CW +: CW]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      directed_rows[0]  = '{16'h0000, 16'h0000, 16'h0000, 1, POS_SAT, 16'h0, 16'h0, POS_SAT};
      directed_rows[1]  = '{16'hC000, 16'h0000, 16'h0000, 1, 16'h0, 16'h0, POS_SAT, 16'h0};
      directed_rows[2]  = '{16'h4000, 16'h0000, 16'h0000, 1, 16'h0, 16'h0, NEG_SAT, 16'h0};
      directed_rows[3]  = '{16'h8000, 16'h8000, 16'h8000, 1, POS_SAT, 16'h0, 16'h0, POS_SAT};
      directed_rows[4]  = '{16'h0000, 16'h4000, 16'h0000, 1, 16'h0, POS_SAT, 16'h0, POS_SAT};
      directed_rows[5]  = '{16'h0000, 16'h0000, 16'h8000, 1, POS_SAT, 16'h0, 16'h0, NEG_SAT};
      directed_rows[6]  = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0, '0, '0, '0};
      directed_rows[7]  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0, '0, '0, '0};
      directed_rows[8]  = '{16'h8001, 16'h0001, 16'hFFFE, 0, '0, '0, '0, '0};
      directed_rows[9]  = '{16'h2000, 16'h6000, 16'hA000, 0, '0, '0, '0, '0};
      directed_rows[10] = '{16'h3FFF, 16'h4001, 16'hBFFF, 0, '0, '0, '0, '0};
      directed_rows[11] = '{16'h5555, 16'hAAAA, 16'h1234, 0, '0, '0, '0, '0};
      directed_rows[12] = '{16'hAAAA, 16'h5555, 16'hEDCB, 0, '0, '0, '0, '0};
      directed_rows[13] = '{16'h0000, 16'hC000, 16'h4000, 0, '0, '0, '0, '0};
      directed_rows[14] = '{16'h1000, 16'hF000, 16'h7000, 0, '0, '0, '0, '0};
      directed_rows[15] = '{16'hE000, 16'h9000, 16'h3000, 0, '0, '0, '0, '0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         logic [OUT_BITS-1:0] calc;
         calc = basis_vectors(directed_rows[i].pitch, directed_rows[i].yaw,
                              directed_rows[i].roll);
         if (directed_rows[i].known) begin
            if (calc[0 +: CW] !== directed_rows[i].fx)
               report_mismatch("table row", i, calc[0 +: CW], directed_rows[i].fx);
            if (calc[CW +: CW] !== directed_rows[i].fy)
               report_mismatch("table row", i, calc[CW +: CW], directed_rows[i].fy);
            if (calc[2*CW +: CW] !== directed_rows[i].fz)
               report_mismatch("table row", i, calc[2*CW +: CW], directed_rows[i].fz);
            if (calc[8*CW +: CW] !== directed_rows[i].uz)
               report_mismatch("table row", i, calc[8*CW +: CW], directed_rows[i].uz);
         end
         send_angles(directed_rows[i].pitch, directed_rows[i].yaw, directed_rows[i].roll);
      end
      drain_results();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 82; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 82; end
            3: begin send_gap_pct = 32; stall_pct = 32; end
            default: begin send_gap_pct = 0; stall_pct = 0; end
         endcase
         if (phase == 4) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (200) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < RANDOM_ITEMS / 5; n++)
            send_angles(16'($urandom), 16'($urandom), 16'($urandom));
         drain_results();
      end

      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_vectors.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
